FILE: src/blec_pkg.sv
package blec_pkg;

    // Store geometry
    localparam int MAX_POINTS  = 1024;
    localparam int DIMS        = 3;
    localparam int STORE_DEPTH = MAX_POINTS * DIMS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = (DIMS > 1) ? $clog2(DIMS) : 1;

    // Field widths
    localparam int COORD_W = 32;
    localparam int POINT_W = 11;
    localparam int PIDX_W  = 10;
    localparam int CIDX_W  = 3;
    localparam int DIST_W  = 31;
    localparam int ERR_W   = 32;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;

    // Square root iteration count
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // Tolerance register
    localparam int                 TOL_W     = 31;
    localparam logic [TOL_W-1:0]   TOL_RESET = 31'd655;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

endpackage

FILE: src/blec_store.sv
module blec_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [blec_pkg::ADDR_W-1:0]   waddr,
    input  logic [blec_pkg::COORD_W-1:0]  wdata,
    input  logic [blec_pkg::ADDR_W-1:0]   raddr_a,
    input  logic [blec_pkg::ADDR_W-1:0]   raddr_b,
    output logic [blec_pkg::COORD_W-1:0]  rdata_a,
    output logic [blec_pkg::COORD_W-1:0]  rdata_b
);

    logic [blec_pkg::COORD_W-1:0] mem [blec_pkg::STORE_DEPTH];
    logic [blec_pkg::COORD_W-1:0] rdata_a_reg;
    logic [blec_pkg::COORD_W-1:0] rdata_b_reg;

    // Write one coordinate
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read both points, registered
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/blec_sqrt.sv
module blec_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [blec_pkg::SUM_W-1:0]   radicand,
    output logic                         done,
    output logic [blec_pkg::ROOT_W-1:0]  root
);

    logic [blec_pkg::SUM_W-1:0]      x_reg,   x_next;
    logic [blec_pkg::SUM_W-1:0]      res_reg, res_next;
    logic [blec_pkg::SUM_W-1:0]      bit_reg, bit_next;
    logic [blec_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                            run_reg;
    logic                            done_reg;
    logic [blec_pkg::SUM_W-1:0]      trial;

    // One digit of the root per cycle
    always_comb
    begin
        trial = res_reg + bit_reg;
        if (x_reg >= trial)
        begin
            x_next   = x_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            x_next   = x_reg;
            res_next = res_reg >> 1;
        end
        bit_next = bit_reg >> 2;
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == blec_pkg::SQRT_CNT_W'(blec_pkg::SQRT_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(blec_pkg::SUM_W - 2){1'b0}}};
        end
        else if (run_reg)
        begin
            x_reg   <= x_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[blec_pkg::ROOT_W-1:0];

endmodule

FILE: src/bond_length_error_check_top.sv
// Channel   Handshake                 Payload
// input     start / busy              operation, point_index, coord_index, coord_value,
//                                     first_point, second_point, target_distance
// config    tolerance_we              tolerance_wdata
// result    result_valid (1 cycle)    error_value, flagged
//
// A load beat leaves busy low, so loads may come every cycle.
// A check beat holds busy through READ, DIFF, MUL and ACC for each dimension (store read,
// difference, multiplier, accumulator), then through ROOT for the 32 root bits at one per
// cycle; the result is registered and its strobe rises at the edge where busy falls.
// Reset clears the sequencer and sets tolerance to 0.01; the store is not cleared.
// The receiver cannot stall; each result shows for exactly one cycle.
module bond_length_error_check_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [blec_pkg::PIDX_W-1:0]    point_index,
    input  logic [blec_pkg::CIDX_W-1:0]    coord_index,
    input  logic signed [blec_pkg::COORD_W-1:0] coord_value,
    input  logic [blec_pkg::POINT_W-1:0]   first_point,
    input  logic [blec_pkg::POINT_W-1:0]   second_point,
    input  logic [blec_pkg::DIST_W-1:0]    target_distance,
    input  logic                           tolerance_we,
    input  logic [blec_pkg::TOL_W-1:0]     tolerance_wdata,
    output logic                           result_valid,
    output logic [blec_pkg::ERR_W-1:0]     error_value,
    output logic                           flagged
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_DIFF = 6'b000100,
        S_MUL  = 6'b001000,
        S_ACC  = 6'b010000,
        S_ROOT = 6'b100000
    } state_t;

    state_t                           state_reg, state_next;
    logic [blec_pkg::TOL_W-1:0]       tol_reg;
    logic [blec_pkg::ADDR_W-1:0]      addr_a_reg, addr_b_reg;
    logic                             ok_a_reg, ok_b_reg;
    logic [blec_pkg::DIM_W-1:0]       dim_reg;
    logic [blec_pkg::DIST_W-1:0]      target_reg;
    logic [blec_pkg::COORD_W-1:0]     mag_reg;
    logic [blec_pkg::SUM_W-1:0]       sq_reg;
    logic [blec_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic                             result_valid_reg;
    logic [blec_pkg::ERR_W-1:0]       error_value_reg;
    logic                             flagged_reg;

    logic                             accept;
    logic                             store_we;
    logic [blec_pkg::ADDR_W-1:0]      store_waddr;
    logic [blec_pkg::COORD_W-1:0]     rdata_a, rdata_b;
    logic signed [blec_pkg::COORD_W:0] coord_a, coord_b, diff;
    logic [blec_pkg::COORD_W:0]       mag_wide;
    logic [blec_pkg::SUM_W:0]         sum_wide;
    logic                             last_dim;
    logic                             root_start;
    logic                             root_done;
    logic [blec_pkg::ROOT_W-1:0]      root;
    logic [blec_pkg::ERR_W-1:0]       target_ext, err;
    logic                             err_over;
    logic                             ok_a_in, ok_b_in;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Load decode: drop writes outside the store
    assign store_we = accept && (operation == blec_pkg::OP_LOAD)
                      && (32'(point_index) < blec_pkg::MAX_POINTS)
                      && (32'(coord_index) < blec_pkg::DIMS);
    assign store_waddr = blec_pkg::ADDR_W'(32'(point_index) * blec_pkg::DIMS
                                           + 32'(coord_index));

    // Point numbers outside 1..MAX_POINTS read as the origin
    assign ok_a_in = (first_point != '0) && (32'(first_point) <= blec_pkg::MAX_POINTS);
    assign ok_b_in = (second_point != '0) && (32'(second_point) <= blec_pkg::MAX_POINTS);

    blec_store u_store (
        .clk     (clk),
        .we      (store_we),
        .waddr   (store_waddr),
        .wdata   (coord_value),
        .raddr_a (addr_a_reg),
        .raddr_b (addr_b_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Difference magnitude of one dimension
    always_comb
    begin
        coord_a  = ok_a_reg ? {rdata_a[blec_pkg::COORD_W-1], rdata_a} : '0;
        coord_b  = ok_b_reg ? {rdata_b[blec_pkg::COORD_W-1], rdata_b} : '0;
        diff     = coord_a - coord_b;
        mag_wide = diff[blec_pkg::COORD_W] ? 33'(-diff) : 33'(diff);
    end

    // Saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign sum_next = sum_wide[blec_pkg::SUM_W] ? '1 : sum_wide[blec_pkg::SUM_W-1:0];
    assign last_dim = (dim_reg == blec_pkg::DIM_W'(blec_pkg::DIMS - 1));
    assign root_start = (state_reg == S_ACC) && last_dim;

    blec_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_next),
        .done     (root_done),
        .root     (root)
    );

    // Length error against target and tolerance
    always_comb
    begin
        target_ext = {1'b0, target_reg};
        err        = (target_ext > root) ? (target_ext - root) : (root - target_ext);
        err_over   = (err > {1'b0, tol_reg});
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == blec_pkg::OP_CHECK))
                begin
                    state_next = S_READ;
                end
            end
            S_READ: state_next = S_DIFF;
            S_DIFF: state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = last_dim ? S_ROOT : S_READ;
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tol_reg          <= blec_pkg::TOL_RESET;
            result_valid_reg <= 1'b0;
            dim_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == S_ROOT) && root_done;
            if (tolerance_we)
            begin
                tol_reg <= tolerance_wdata;
            end
            if (accept)
            begin
                dim_reg <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                dim_reg <= dim_reg + 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_a_reg   <= ok_a_in;
            ok_b_reg   <= ok_b_in;
            addr_a_reg <= blec_pkg::ADDR_W'((32'(first_point) - 32'd1) * blec_pkg::DIMS);
            addr_b_reg <= blec_pkg::ADDR_W'((32'(second_point) - 32'd1) * blec_pkg::DIMS);
            target_reg <= target_distance;
            sum_reg    <= '0;
        end
        if (state_reg == S_DIFF)
        begin
            mag_reg <= mag_wide[blec_pkg::COORD_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
        if (state_reg == S_ACC)
        begin
            sum_reg    <= sum_next;
            addr_a_reg <= addr_a_reg + 1'b1;
            addr_b_reg <= addr_b_reg + 1'b1;
        end
        if ((state_reg == S_ROOT) && root_done)
        begin
            error_value_reg <= err_over ? err : '0;
            flagged_reg     <= err_over;
        end
    end

    assign result_valid = result_valid_reg;
    assign error_value  = error_value_reg;
    assign flagged      = flagged_reg;

endmodule
